>>> rtl/core/bmos_pkg.sv
`default_nettype none
package bmos_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int QUO_W        = 17;
  localparam int QCNT_W       = $clog2(QUO_W);

  localparam logic signed [34:0] PI_Z      = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Z = 35'sd1686629713;
  localparam logic signed [32:0] CORDIC_K  = 33'sd652032874;

  localparam logic signed [20:0] PI_H     = 21'sd25736;
  localparam logic signed [20:0] TWO_PI_H = 21'sd51472;

  localparam logic signed [65:0] RND13 = 66'sd4096;
  localparam logic signed [65:0] RND29 = 66'sd536870912;
  localparam logic signed [65:0] RND37 = 66'sd137438953472;

  localparam logic [2:0] CFG_WHEEL_BASE    = 3'd0;
  localparam logic [2:0] CFG_TIME_STEP     = 3'd1;
  localparam logic [2:0] CFG_START_X       = 3'd2;
  localparam logic [2:0] CFG_START_Y       = 3'd3;
  localparam logic [2:0] CFG_START_HEADING = 3'd4;

  localparam logic OP_CMD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CORD_H,
    ST_CORD_S,
    ST_M_VC,
    ST_M_VS,
    ST_M_VSD,
    ST_M_DEN,
    ST_M_PX,
    ST_M_PY,
    ST_Y,
    ST_DIV,
    ST_M_W,
    ST_HEAD,
    ST_WRAP,
    ST_OUT
  } state_t;

  function automatic logic [29:0] atan_lookup(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'h3243F6A8;
      5'd1:  r = 30'h1DAC6705;
      5'd2:  r = 30'h0FADBAFC;
      5'd3:  r = 30'h07F56EA6;
      5'd4:  r = 30'h03FEAB76;
      5'd5:  r = 30'h01FFD55B;
      5'd6:  r = 30'h00FFFAAA;
      5'd7:  r = 30'h007FFF55;
      5'd8:  r = 30'h003FFFEA;
      5'd9:  r = 30'h001FFFFD;
      5'd10: r = 30'h000FFFFF;
      5'd11: r = 30'h0007FFFF;
      5'd12: r = 30'h0003FFFF;
      5'd13: r = 30'h0001FFFF;
      5'd14: r = 30'h0000FFFF;
      5'd15: r = 30'h00007FFF;
      5'd16: r = 30'h00003FFF;
      5'd17: r = 30'h00001FFF;
      5'd18: r = 30'h00000FFF;
      5'd19: r = 30'h000007FF;
      5'd20: r = 30'h000003FF;
      5'd21: r = 30'h000001FF;
      5'd22: r = 30'h000000FF;
      5'd23: r = 30'h0000007F;
      default: r = 30'h0;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [65:0] v);
    logic signed [15:0] r;
    if (v > 66'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -66'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/bmos_cordic.sv
`default_nettype none
module bmos_cordic (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [15:0] ang,
  output logic                    done,
  output logic signed [32:0]      cos_o,
  output logic signed [32:0]      sin_o
);

  logic                             busy_r;
  logic                             done_r;
  logic [bmos_pkg::STEP_W-1:0]      cnt_r;
  logic signed [32:0]               x_r;
  logic signed [32:0]               y_r;
  logic signed [34:0]               z_r;
  logic                             neg_r;
  logic signed [32:0]               cos_r;
  logic signed [32:0]               sin_r;

  logic signed [34:0] z0;
  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic signed [34:0] at;
  logic signed [32:0] x_nxt;
  logic signed [32:0] y_nxt;
  logic signed [34:0] z_nxt;
  logic               last;

  assign z0   = {{2{ang[15]}}, ang, 17'b0};
  assign last = (cnt_r == bmos_pkg::STEP_W'(bmos_pkg::CORDIC_STEPS - 1));

  always_comb begin
    dx = y_r >>> cnt_r;
    dy = x_r >>> cnt_r;
    at = $signed({5'b0, bmos_pkg::atan_lookup(5'(cnt_r))});
    if (!z_r[34]) begin
      x_nxt = x_r - dx;
      y_nxt = y_r + dy;
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + dx;
      y_nxt = y_r - dy;
      z_nxt = z_r + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && last) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= '0;
      x_r   <= bmos_pkg::CORDIC_K;
      y_r   <= '0;
      if (z0 > bmos_pkg::HALF_PI_Z) begin
        z_r   <= z0 - bmos_pkg::PI_Z;
        neg_r <= 1'b1;
      end else if (z0 < -bmos_pkg::HALF_PI_Z) begin
        z_r   <= z0 + bmos_pkg::PI_Z;
        neg_r <= 1'b1;
      end else begin
        z_r   <= z0;
        neg_r <= 1'b0;
      end
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      z_r   <= z_nxt;
      if (last) begin
        cos_r <= neg_r ? -x_nxt : x_nxt;
        sin_r <= neg_r ? -y_nxt : y_nxt;
      end
    end
  end

  assign done  = done_r;
  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule
`default_nettype wire

>>> rtl/core/bmos_div.sv
`default_nettype none
module bmos_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [61:0] num,
  input  wire logic signed [49:0] den,
  output logic                    done,
  output logic signed [15:0]      quo
);

  logic                              busy_r;
  logic                              done_r;
  logic [bmos_pkg::QCNT_W-1:0]       cnt_r;
  logic [66:0]                       rem_r;
  logic [66:0]                       dsh_r;
  logic [bmos_pkg::QUO_W-1:0]        q_r;
  logic                              neg_r;
  logic                              zero_r;
  logic                              ovf_r;
  logic                              nneg_r;
  logic                              nnz_r;
  logic signed [15:0]                quo_r;

  logic [61:0]                 nmag;
  logic [49:0]                 dmag;
  logic                        ge;
  logic [bmos_pkg::QUO_W-1:0]  q_nxt;
  logic [bmos_pkg::QUO_W-1:0]  q_neg;
  logic signed [15:0]          res;

  always_comb begin
    nmag  = num[61] ? 62'(-num) : 62'(num);
    dmag  = den[49] ? 50'(-den) : 50'(den);
    ge    = (rem_r >= dsh_r);
    q_nxt = {q_r[bmos_pkg::QUO_W-2:0], ge};
    q_neg = -q_nxt;
    if (zero_r) begin
      res = !nnz_r ? 16'sd0 : (nneg_r ? 16'sh8000 : 16'sh7FFF);
    end else if (ovf_r) begin
      res = neg_r ? 16'sh8000 : 16'sh7FFF;
    end else if (neg_r) begin
      res = (q_nxt > 17'd32768) ? 16'sh8000 : $signed(q_neg[15:0]);
    end else begin
      res = (q_nxt > 17'd32767) ? 16'sh7FFF : $signed(q_nxt[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r  <= bmos_pkg::QCNT_W'(bmos_pkg::QUO_W - 1);
      rem_r  <= {5'b0, nmag};
      dsh_r  <= {1'b0, dmag, 16'b0};
      q_r    <= '0;
      neg_r  <= num[61] ^ den[49];
      zero_r <= (den == '0);
      ovf_r  <= ({5'b0, nmag} >= {dmag, 17'b0});
      nneg_r <= num[61];
      nnz_r  <= (num != '0);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      q_r   <= q_nxt;
      dsh_r <= dsh_r >> 1;
      if (ge) begin
        rem_r <= rem_r - dsh_r;
      end
      if (cnt_r == '0) begin
        quo_r <= res;
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

>>> rtl/core/bicycle_model_odometry_step_core.sv
// Kinematic bicycle dead-reckoning core.
// Input channel (in_valid/in_ready) takes one word: op 0 stores a speed and
// steering command and gives no result; op 1 is a time tick that gives one
// odometry word on the output channel (out_valid/out_ready).
// A tick before any command reports the start pose. A regular tick takes two
// passes of one shared 16-step CORDIC (heading, then steering angle), seven
// products through one shared 48x18 multiplier, a 17-step shift-subtract
// divider for the yaw rate and repeated 2*pi corrections of the heading.
// The core takes one word at a time; in_ready is high only while idle.
// The result sits in an output register; a stalled receiver holds it, and a
// following tick waits at its last step until that register is free.
// Configuration is written through cfg_we/cfg_idx/cfg_wdata while idle; the
// core does not enforce this, so the user must keep to it. Reset (rst_n low,
// synchronous) restores the default registers, loads the pose from them and
// clears the command state; no clearing pass is needed.
`default_nettype none
module bicycle_model_odometry_step_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_idx,
  input  wire logic [31:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_op,
  input  wire logic signed [15:0] in_cmd_speed,
  input  wire logic signed [14:0] in_cmd_steer,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_pos_x,
  output logic signed [31:0]      out_pos_y,
  output logic signed [15:0]      out_heading,
  output logic signed [15:0]      out_vel_x,
  output logic signed [15:0]      out_vel_y,
  output logic signed [15:0]      out_yaw_rate,
  output logic signed [15:0]      out_speed_now,
  output logic signed [14:0]      out_steer_now
);

  bmos_pkg::state_t state_r, state_nxt;

  logic [15:0]        wb_r;
  logic [15:0]        dt_r;
  logic signed [31:0] sx_r;
  logic signed [31:0] sy_r;
  logic signed [15:0] sh_r;

  logic [31:0]        x_acc_r;
  logic [31:0]        y_acc_r;
  logic signed [15:0] hd_acc_r;
  logic signed [15:0] spd_r;
  logic signed [14:0] str_r;
  logic signed [15:0] pspd_r;
  logic signed [14:0] pstr_r;
  logic               started_r;
  logic               pre_r;
  logic               out_valid_r;

  logic signed [32:0] c_r, s_r, cd_r, sd_r;
  logic signed [65:0] prod_r;
  logic signed [47:0] p1_r, p2_r;
  logic signed [61:0] num_r;
  logic signed [49:0] den_r;
  logic signed [15:0] w_r, vx_r, vy_r;
  logic signed [20:0] h_r;

  logic signed [31:0] opx_r, opy_r;
  logic signed [15:0] ohd_r, ovx_r, ovy_r, ow_r, ospd_r;
  logic signed [14:0] ostr_r;

  logic               accept;
  logic               cord_start;
  logic signed [15:0] cord_ang;
  logic               cord_done;
  logic signed [32:0] cord_c, cord_s;
  logic               div_start;
  logic               div_done;
  logic signed [15:0] div_quo;
  logic signed [47:0] mul_a;
  logic signed [17:0] mul_b;
  logic               slot_free;
  logic               h_ok;
  logic signed [17:0] dt_s;
  logic signed [17:0] wb_s;
  logic signed [65:0] xd, yd, hd;

  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign h_ok      = (h_r <= bmos_pkg::PI_H) && (h_r >= -bmos_pkg::PI_H);
  assign dt_s      = $signed({2'b00, dt_r});
  assign wb_s      = $signed({2'b00, wb_r});
  assign xd        = (prod_r + bmos_pkg::RND37) >>> 38;
  assign yd        = (prod_r + bmos_pkg::RND37) >>> 38;
  assign hd        = (prod_r + bmos_pkg::RND13) >>> 13;

  bmos_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start),
    .ang   (cord_ang),
    .done  (cord_done),
    .cos_o (cord_c),
    .sin_o (cord_s)
  );

  bmos_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bmos_pkg::ST_IDLE: begin
        if (accept && in_op == bmos_pkg::OP_TICK) begin
          state_nxt = started_r ? bmos_pkg::ST_CORD_H : bmos_pkg::ST_OUT;
        end
      end
      bmos_pkg::ST_CORD_H: if (cord_done) state_nxt = bmos_pkg::ST_CORD_S;
      bmos_pkg::ST_CORD_S: if (cord_done) state_nxt = bmos_pkg::ST_M_VC;
      bmos_pkg::ST_M_VC:   state_nxt = bmos_pkg::ST_M_VS;
      bmos_pkg::ST_M_VS:   state_nxt = bmos_pkg::ST_M_VSD;
      bmos_pkg::ST_M_VSD:  state_nxt = bmos_pkg::ST_M_DEN;
      bmos_pkg::ST_M_DEN:  state_nxt = bmos_pkg::ST_M_PX;
      bmos_pkg::ST_M_PX:   state_nxt = bmos_pkg::ST_M_PY;
      bmos_pkg::ST_M_PY:   state_nxt = bmos_pkg::ST_Y;
      bmos_pkg::ST_Y:      state_nxt = bmos_pkg::ST_DIV;
      bmos_pkg::ST_DIV:    if (div_done) state_nxt = bmos_pkg::ST_M_W;
      bmos_pkg::ST_M_W:    state_nxt = bmos_pkg::ST_HEAD;
      bmos_pkg::ST_HEAD:   state_nxt = bmos_pkg::ST_WRAP;
      bmos_pkg::ST_WRAP:   if (h_ok) state_nxt = bmos_pkg::ST_OUT;
      bmos_pkg::ST_OUT:    if (slot_free) state_nxt = bmos_pkg::ST_IDLE;
      default:             state_nxt = bmos_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cord_start = 1'b0;
    cord_ang   = hd_acc_r;
    div_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state_r)
      bmos_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cord_start = accept && in_op == bmos_pkg::OP_TICK && started_r;
      end
      bmos_pkg::ST_CORD_H: begin
        cord_start = cord_done;
        cord_ang   = 16'(str_r);
      end
      bmos_pkg::ST_M_VC: begin
        mul_a = 48'(c_r);
        mul_b = 18'(spd_r);
      end
      bmos_pkg::ST_M_VS: begin
        mul_a = 48'(s_r);
        mul_b = 18'(spd_r);
      end
      bmos_pkg::ST_M_VSD: begin
        mul_a = 48'(sd_r);
        mul_b = 18'(spd_r);
      end
      bmos_pkg::ST_M_DEN: begin
        mul_a = 48'(cd_r);
        mul_b = wb_s;
      end
      bmos_pkg::ST_M_PX: begin
        mul_a = p1_r;
        mul_b = dt_s;
      end
      bmos_pkg::ST_M_PY: begin
        mul_a     = p2_r;
        mul_b     = dt_s;
        div_start = 1'b1;
      end
      bmos_pkg::ST_M_W: begin
        mul_a = 48'(w_r);
        mul_b = dt_s;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bmos_pkg::ST_IDLE;
      wb_r        <= 16'd2458;
      dt_r        <= 16'd655;
      sx_r        <= 32'sd65536;
      sy_r        <= 32'sd65536;
      sh_r        <= '0;
      x_acc_r     <= 32'd65536;
      y_acc_r     <= 32'd65536;
      hd_acc_r    <= '0;
      spd_r       <= '0;
      str_r       <= '0;
      pspd_r      <= '0;
      pstr_r      <= '0;
      started_r   <= 1'b0;
      pre_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          bmos_pkg::CFG_WHEEL_BASE:    wb_r <= cfg_wdata[15:0];
          bmos_pkg::CFG_TIME_STEP:     dt_r <= cfg_wdata[15:0];
          bmos_pkg::CFG_START_X:       sx_r <= $signed(cfg_wdata);
          bmos_pkg::CFG_START_Y:       sy_r <= $signed(cfg_wdata);
          bmos_pkg::CFG_START_HEADING: sh_r <= $signed(cfg_wdata[15:0]);
          default: begin
          end
        endcase
      end
      if (accept) begin
        pre_r <= !started_r;
        if (in_op == bmos_pkg::OP_CMD) begin
          pspd_r    <= in_cmd_speed;
          pstr_r    <= in_cmd_steer;
          started_r <= 1'b1;
          if (!started_r) begin
            x_acc_r  <= sx_r;
            y_acc_r  <= sy_r;
            hd_acc_r <= sh_r;
          end
        end
      end
      if (state_r == bmos_pkg::ST_M_PY) begin
        x_acc_r <= x_acc_r + xd[31:0];
      end
      if (state_r == bmos_pkg::ST_Y) begin
        y_acc_r <= y_acc_r + yd[31:0];
      end
      if (state_r == bmos_pkg::ST_WRAP && h_ok) begin
        hd_acc_r <= h_r[15:0];
        spd_r    <= pspd_r;
        str_r    <= pstr_r;
      end
      if (state_r == bmos_pkg::ST_OUT && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (state_r)
      bmos_pkg::ST_CORD_H: begin
        if (cord_done) begin
          c_r <= cord_c;
          s_r <= cord_s;
        end
      end
      bmos_pkg::ST_CORD_S: begin
        if (cord_done) begin
          cd_r <= cord_c;
          sd_r <= cord_s;
        end
      end
      bmos_pkg::ST_M_VS: begin
        p1_r <= prod_r[47:0];
        vx_r <= bmos_pkg::sat16((prod_r + bmos_pkg::RND29) >>> 30);
      end
      bmos_pkg::ST_M_VSD: begin
        p2_r <= prod_r[47:0];
        vy_r <= bmos_pkg::sat16((prod_r + bmos_pkg::RND29) >>> 30);
      end
      bmos_pkg::ST_M_DEN: num_r <= {prod_r[47:0], 14'b0};
      bmos_pkg::ST_M_PX:  den_r <= prod_r[49:0];
      bmos_pkg::ST_DIV:   if (div_done) w_r <= div_quo;
      bmos_pkg::ST_HEAD:  h_r <= 21'(hd_acc_r) + $signed(hd[20:0]);
      bmos_pkg::ST_WRAP: begin
        if (h_r > bmos_pkg::PI_H) begin
          h_r <= h_r - bmos_pkg::TWO_PI_H;
        end else if (h_r < -bmos_pkg::PI_H) begin
          h_r <= h_r + bmos_pkg::TWO_PI_H;
        end
      end
      bmos_pkg::ST_OUT: begin
        if (slot_free) begin
          if (pre_r) begin
            opx_r  <= sx_r;
            opy_r  <= sy_r;
            ohd_r  <= sh_r;
            ovx_r  <= '0;
            ovy_r  <= '0;
            ow_r   <= '0;
            ospd_r <= '0;
            ostr_r <= '0;
          end else begin
            opx_r  <= $signed(x_acc_r);
            opy_r  <= $signed(y_acc_r);
            ohd_r  <= hd_acc_r;
            ovx_r  <= vx_r;
            ovy_r  <= vy_r;
            ow_r   <= w_r;
            ospd_r <= spd_r;
            ostr_r <= str_r;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_pos_x     = opx_r;
  assign out_pos_y     = opy_r;
  assign out_heading   = ohd_r;
  assign out_vel_x     = ovx_r;
  assign out_vel_y     = ovy_r;
  assign out_yaw_rate  = ow_r;
  assign out_speed_now = ospd_r;
  assign out_steer_now = ostr_r;

endmodule
`default_nettype wire
